>>> rtl/chained_hash_key_table_core_macros.svh
// assertion macros for the checker file
`ifndef CHAINED_HASH_KEY_TABLE_CORE_MACROS_SVH
`define CHAINED_HASH_KEY_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chkt assertion failed");

// next-cycle implication, disabled during reset
`define CHKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chkt assertion failed");

`endif

>>> rtl/chkt_pkg.sv
// shared constants and types of the chained hash key table
package chkt_pkg;

  localparam int BUCKETS = 256;
  localparam int NODES   = 256;
  localparam int IDX_W   = 9;
  localparam int ADDR_W  = 8;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int BC_W    = 9;

  localparam logic [IDX_W-1:0] NIL       = 9'd256;
  localparam logic [31:0]      HASH_INIT = 32'd5381;
  localparam logic [BC_W-1:0]  BC_RESET  = 9'd256;

  // request kinds
  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;
  localparam logic [1:0] REQ_RSV = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_MOD      = 12'b000000000010,
    S_HEAD_RD  = 12'b000000000100,
    S_HEAD_CK  = 12'b000000001000,
    S_WALK     = 12'b000000010000,
    S_WALK_CK  = 12'b000000100000,
    S_ACT      = 12'b000001000000,
    S_ALLOC_CK = 12'b000010000000,
    S_INS      = 12'b000100000000,
    S_INS_CK   = 12'b001000000000,
    S_INS_LN   = 12'b010000000000,
    S_DEL_FREE = 12'b100000000000
  } state_t;

endpackage

>>> rtl/chained_hash_key_table_core.sv
// top level of the chained hash key table
//
// channel   dir  tdata                            tuser        tlast
// s_axis    in   [7:0] key_byte, [39:8] value_in  req_type     key_last
// m_axis    out  [31:0] value_out                 status       -
// cfg       in   cfg_data[8:0] bucket_count       (cfg_we)     -
//
// a non-last key byte only updates the hash
// a last byte runs a bit-serial modulo in the subtractor, then a head read, then a walk
// of the chain nodes (with a final check to end a miss), then the update, all on
// single-port-write rams
// reset clears the bucket valid bits at once, so no clearing pass is needed
// input is not ready while a request runs or while a result waits to be taken
module chained_hash_key_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // key_byte[7:0], value_in[39:8]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_out[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic [chkt_pkg::BC_W-1:0] cfg_data
);
  import chkt_pkg::*;

  state_t state;

  logic [31:0]       hash;
  logic [KEY_W-1:0]  key;
  logic [1:0]        req;
  logic [VAL_W-1:0]  val_in;
  logic [BC_W-1:0]   bucket_count;
  logic [BC_W-1:0]   rem;
  logic [4:0]        bit_cnt;
  logic [IDX_W-1:0]  head, cur, prev, steps, node_new, free_head, fresh;
  logic [VAL_W-1:0]  node_val;
  logic [IDX_W-1:0]  node_lnk;
  logic              found;
  logic [BUCKETS-1:0] head_valid;

  logic [31:0]       hash_next;
  logic [BC_W-1:0]   divisor;
  logic [BC_W:0]     trial;
  logic [BC_W:0]     trial_sub;
  logic              accept;

  // ram ports
  logic              h_we, k_we, v_we, l_we;
  logic [ADDR_W-1:0] h_waddr, k_waddr, v_waddr, l_waddr, l_raddr;
  logic [IDX_W-1:0]  h_wdata, h_rdata, l_wdata, l_rdata;
  logic [KEY_W-1:0]  k_rdata;
  logic [VAL_W-1:0]  v_rdata;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);

  // time33 step: h*33 + byte
  assign hash_next = hash + {hash[26:0], 5'b0} + {24'b0, s_tdata[7:0]};

  // zero or oversized count selects all buckets
  assign divisor = (bucket_count == '0 || bucket_count > BC_RESET) ? BC_RESET : bucket_count;

  // one restoring division step
  assign trial     = {rem, key[bit_cnt]};
  assign trial_sub = trial - {1'b0, divisor};

  // ram port control
  always_comb begin
    h_we = 1'b0; h_waddr = rem[ADDR_W-1:0]; h_wdata = node_new;
    k_we = 1'b0; k_waddr = node_new[ADDR_W-1:0];
    v_we = 1'b0; v_waddr = node_new[ADDR_W-1:0];
    l_we = 1'b0; l_waddr = node_new[ADDR_W-1:0]; l_wdata = NIL;
    l_raddr = cur[ADDR_W-1:0];
    unique case (state)
      S_ACT: begin
        if (req == REQ_SET && found) begin
          v_we = 1'b1;
          v_waddr = cur[ADDR_W-1:0];
        end else if (req == REQ_SET) begin
          l_raddr = free_head[ADDR_W-1:0];
        end else if (req == REQ_DEL && found) begin
          if (prev == NIL) begin
            h_we = 1'b1;
            h_wdata = node_lnk;
          end else begin
            l_we = 1'b1;
            l_waddr = prev[ADDR_W-1:0];
            l_wdata = node_lnk;
          end
        end
      end
      S_INS: begin
        k_we = 1'b1;
        v_we = 1'b1;
        l_raddr = head[ADDR_W-1:0];
        if (head == NIL) begin
          l_we = 1'b1;
          h_we = 1'b1;
        end
      end
      S_INS_CK: begin
        l_we = 1'b1;
        l_wdata = l_rdata;
      end
      S_INS_LN: begin
        l_we = 1'b1;
        l_waddr = head[ADDR_W-1:0];
        l_wdata = node_new;
      end
      S_DEL_FREE: begin
        l_we = 1'b1;
        l_waddr = cur[ADDR_W-1:0];
        l_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  // control state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hash         <= HASH_INIT;
      bucket_count <= BC_RESET;
      head_valid   <= '0;
      free_head    <= NIL;
      fresh        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tlast) begin
              key     <= hash_next[KEY_W-1:0];
              hash    <= HASH_INIT;
              req     <= s_tuser;
              val_in  <= s_tdata[39:8];
              rem     <= '0;
              bit_cnt <= 5'(KEY_W - 1);
              state   <= S_MOD;
            end else begin
              hash <= hash_next;
            end
          end
        end
        S_MOD: begin
          rem <= (trial >= {1'b0, divisor}) ? trial_sub[BC_W-1:0] : trial[BC_W-1:0];
          if (bit_cnt == '0) begin
            state <= S_HEAD_RD;
          end else begin
            bit_cnt <= bit_cnt - 5'd1;
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_CK;
        end
        S_HEAD_CK: begin
          head  <= head_valid[rem[ADDR_W-1:0]] ? h_rdata : NIL;
          cur   <= head_valid[rem[ADDR_W-1:0]] ? h_rdata : NIL;
          prev  <= NIL;
          steps <= '0;
          found <= 1'b0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (cur == NIL || steps == IDX_W'(NODES)) begin
            state <= S_ACT;
          end else begin
            state <= S_WALK_CK;
          end
        end
        S_WALK_CK: begin
          node_val <= v_rdata;
          node_lnk <= l_rdata;
          if (k_rdata == key) begin
            found <= 1'b1;
            state <= S_ACT;
          end else begin
            prev  <= cur;
            cur   <= l_rdata;
            steps <= steps + 9'd1;
            state <= S_WALK;
          end
        end
        S_ACT: begin
          if (req == REQ_SET && !found) begin
            if (free_head != NIL) begin
              node_new <= free_head;
              state    <= S_ALLOC_CK;
            end else if (fresh != IDX_W'(NODES)) begin
              node_new <= fresh;
              fresh    <= fresh + 9'd1;
              state    <= S_INS;
            end else begin
              m_tvalid <= 1'b1;
              m_tuser  <= ST_FULL;
              m_tdata  <= '0;
              state    <= S_IDLE;
            end
          end else if (req == REQ_DEL && found) begin
            state <= S_DEL_FREE;
          end else begin
            m_tvalid <= 1'b1;
            m_tuser  <= found ? ST_OK : ST_MISS;
            m_tdata  <= (found && req != REQ_SET) ? node_val : '0;
            state    <= S_IDLE;
          end
        end
        S_ALLOC_CK: begin
          free_head <= l_rdata;
          state     <= S_INS;
        end
        S_INS: begin
          if (head == NIL) begin
            head_valid[rem[ADDR_W-1:0]] <= 1'b1;
            m_tvalid <= 1'b1;
            m_tuser  <= ST_OK;
            m_tdata  <= '0;
            state    <= S_IDLE;
          end else begin
            state <= S_INS_CK;
          end
        end
        S_INS_CK: begin
          state <= S_INS_LN;
        end
        S_INS_LN: begin
          m_tvalid <= 1'b1;
          m_tuser  <= ST_OK;
          m_tdata  <= '0;
          state    <= S_IDLE;
        end
        S_DEL_FREE: begin
          free_head <= cur;
          m_tvalid  <= 1'b1;
          m_tuser   <= ST_OK;
          m_tdata   <= node_val;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // bucket heads
  chkt_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(rem[ADDR_W-1:0]), .rdata(h_rdata)
  );

  // node hashes
  chkt_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_node_key (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(key),
    .raddr(cur[ADDR_W-1:0]), .rdata(k_rdata)
  );

  // node values
  chkt_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_node_value (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(val_in),
    .raddr(cur[ADDR_W-1:0]), .rdata(v_rdata)
  );

  // node links
  chkt_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_node_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

endmodule

>>> rtl/chkt_ram.sv
// generic single-write, single-read ram with registered read
module chkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/chkt_checker.sv
// port-level checker for the chained hash key table, bound to the top level
`include "chained_hash_key_table_core_macros.svh"

module chkt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [1:0] m_tuser
);

  // a stalled result stays offered
  `CHKT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  // no request taken while a result is stuck
  `CHKT_ASSERT_NOW(a_no_accept_on_stall, m_tvalid && !m_tready, !s_tready)
  // a final byte starts a multi-cycle operation
  `CHKT_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid)
  // status is one of the three codes
  `CHKT_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3)

endmodule

bind chained_hash_key_table_core chkt_checker u_chkt_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);
